// ----- rtl/chcv_pkg.sv -----
package chcv_pkg;

  localparam int CENSUS_W         = 64;
  localparam int COST_W           = 20;
  localparam int DISP_W           = 7;
  localparam int COL_W            = 7;
  localparam int COSTS_PER_RESULT = 4;
  localparam int LANE_W           = 2;
  localparam int GRP_W            = DISP_W - LANE_W;
  localparam int HD_W             = 7;
  localparam int RANGE_W          = 8;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 2;

  localparam logic [COST_W-1:0]  SKY_COST = COST_W'(999999);
  localparam logic [COL_W-1:0]   COL_MAX  = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_CODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_SCALE = 1'b1;

  // Disparity range codes.
  localparam logic [1:0] RANGE_CODE_32  = 2'd0;
  localparam logic [1:0] RANGE_CODE_64  = 2'd1;
  localparam logic [1:0] RANGE_CODE_RST = RANGE_CODE_64;

  typedef logic [COST_W-1:0]   cost_t;
  typedef logic [CENSUS_W-1:0] census_t;
  typedef logic [LANE_W-1:0]   lane_sel_t;

endpackage

// ----- rtl/census_hamming_cost_volume_unit.sv -----
// An input transaction loads the pixel context; each group's bank reads are registered and
// its costs go to the output register. in_stall holds off a new pixel until the last group
// is there. With out_stall low, one group of four costs leaves per cycle, paced by the single
// read port of each of the four history banks and the four-lane Hamming unit behind them.
// Reset (rst_n low, synchronous): control clears, column count goes to zero, range code to
// 64 disparities and scale to one. The history banks are not cleared.
module census_hamming_cost_volume_unit
  import chcv_pkg::*;
#(
  parameter int MAX_DISPARITY = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CENSUS_W-1:0]   in_left_census,
  input  logic [CENSUS_W-1:0]   in_right_census,
  input  logic                  in_sky_pixel,
  input  logic                  in_row_start,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COST_W-1:0]     out_cost_a,
  output logic [COST_W-1:0]     out_cost_b,
  output logic [COST_W-1:0]     out_cost_c,
  output logic [COST_W-1:0]     out_cost_d,
  output logic [DISP_W-1:0]     out_first_disp,
  output logic                  out_last_group
);

  // The right-image history is a circular buffer deep enough for the largest offset.
  // It is split into four banks on the low address bits: the four costs of a group
  // read at most four consecutive addresses, which always fall into different banks.
  localparam int HIST_DEPTH = 1 << $clog2(MAX_DISPARITY);
  localparam int PTR_W      = $clog2(HIST_DEPTH);
  localparam int ROWS       = HIST_DEPTH / COSTS_PER_RESULT;
  localparam int ROW_W      = PTR_W - LANE_W;

  // Eight-bit slices are counted in parallel and then summed.
  function automatic logic [HD_W-1:0] hamming_weight(input census_t v);
    logic [3:0]      byte_cnt [CENSUS_W/8];
    logic [HD_W-1:0] sum;
    for (int b = 0; b < CENSUS_W / 8; b++) begin
      byte_cnt[b] = '0;
      for (int i = 0; i < 8; i++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(v[b*8+i]);
      end
    end
    sum = '0;
    for (int b = 0; b < CENSUS_W / 8; b++) begin
      sum = sum + HD_W'(byte_cnt[b]);
    end
    return sum;
  endfunction

  // Configuration registers.
  logic [1:0]       range_code_r;
  logic             half_scale_r;

  // Sequencer and pixel context.
  logic             busy_r;
  logic             pend_r;
  logic [GRP_W-1:0] grp_r;
  logic [PTR_W-1:0] wp_r;
  logic [COL_W-1:0] col_r;
  census_t          left_r;
  logic             sky_r;

  // Context of the group whose bank reads are in flight.
  logic [GRP_W-1:0] pend_grp_r;
  logic             pend_last_r;
  lane_sel_t        pend_sel_r [COSTS_PER_RESULT];

  // Output register.
  logic             out_valid_r;
  cost_t            out_cost_r [COSTS_PER_RESULT];
  logic [DISP_W-1:0] out_first_disp_r;
  logic             out_last_r;

  census_t          bank_rd_r [COSTS_PER_RESULT];

  logic             in_accept;
  logic             out_free;
  logic             issue;
  logic             load;
  logic [PTR_W-1:0] wr_addr;
  logic [RANGE_W-1:0] range_w;
  logic [RANGE_W-1:0] range_rnd;
  logic [GRP_W-1:0] grp_last;
  logic             grp_is_last;

  logic [DISP_W-1:0] lane_d    [COSTS_PER_RESULT];
  logic [DISP_W-1:0] lane_off  [COSTS_PER_RESULT];
  logic [DISP_W-1:0] lane_eff  [COSTS_PER_RESULT];
  logic [PTR_W-1:0]  lane_addr [COSTS_PER_RESULT];
  logic [ROW_W-1:0]  bank_row  [COSTS_PER_RESULT];
  cost_t             lane_cost [COSTS_PER_RESULT];

  assign in_stall  = busy_r || pend_r;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  // A new group is read whenever the group already in flight can move on this cycle.
  assign issue     = busy_r && (!pend_r || out_free);
  assign load      = pend_r && out_free;
  assign wr_addr   = wp_r + PTR_W'(1);

  // Active range: the configured code, cut to what the history can hold.
  always_comb begin
    case (range_code_r)
      RANGE_CODE_32: range_w = RANGE_W'(32);
      RANGE_CODE_64: range_w = RANGE_W'(64);
      default:       range_w = RANGE_W'(128);
    endcase
    if (range_w > RANGE_W'(MAX_DISPARITY)) begin
      range_w = RANGE_W'(MAX_DISPARITY);
    end
    range_rnd   = range_w + RANGE_W'(COSTS_PER_RESULT - 1);
    grp_last    = GRP_W'(range_rnd[RANGE_W-1:LANE_W] - 1'b1);
    grp_is_last = (grp_r == grp_last);
  end

  // History addressing. An offset past the row start is clamped to the column count,
  // which lands on the row's first pixel.
  always_comb begin
    for (int k = 0; k < COSTS_PER_RESULT; k++) begin
      lane_d[k]    = {grp_r, LANE_W'(k)};
      lane_off[k]  = half_scale_r ? (lane_d[k] >> 1) : lane_d[k];
      lane_eff[k]  = (lane_off[k] < col_r) ? lane_off[k] : col_r;
      lane_addr[k] = wp_r - lane_eff[k][PTR_W-1:0];
    end
    // Lanes that share a bank share the same address, so any of them may steer it.
    for (int b = 0; b < COSTS_PER_RESULT; b++) begin
      bank_row[b] = lane_addr[0][PTR_W-1:LANE_W];
      for (int k = COSTS_PER_RESULT - 1; k >= 0; k--) begin
        if (lane_addr[k][LANE_W-1:0] == LANE_W'(b)) begin
          bank_row[b] = lane_addr[k][PTR_W-1:LANE_W];
        end
      end
    end
  end

  for (genvar b = 0; b < COSTS_PER_RESULT; b++) begin : g_bank
    census_t hist_mem [ROWS];

    always_ff @(posedge clk) begin
      if (in_accept && (wr_addr[LANE_W-1:0] == LANE_W'(b))) begin
        hist_mem[wr_addr[PTR_W-1:LANE_W]] <= in_right_census;
      end
    end

    always_ff @(posedge clk) begin
      if (issue) begin
        bank_rd_r[b] <= hist_mem[bank_row[b]];
      end
    end
  end

  // Four Hamming distances from the registered bank data. Sky pixels take the fixed
  // cost pattern, and lanes past the active range report zero.
  always_comb begin
    logic [DISP_W-1:0] d;
    for (int k = 0; k < COSTS_PER_RESULT; k++) begin
      d = {pend_grp_r, LANE_W'(k)};
      if (RANGE_W'(d) >= range_w) begin
        lane_cost[k] = '0;
      end else if (sky_r) begin
        lane_cost[k] = (d == '0) ? '0 : SKY_COST;
      end else begin
        lane_cost[k] = COST_W'(hamming_weight(left_r ^ bank_rd_r[pend_sel_r[k]]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_code_r <= RANGE_CODE_RST;
      half_scale_r <= 1'b0;
      busy_r       <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      grp_r        <= '0;
      wp_r         <= '0;
      col_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_RANGE_CODE: range_code_r <= cfg_wdata;
          REG_HALF_SCALE: half_scale_r <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (in_accept) begin
        busy_r <= 1'b1;
        grp_r  <= '0;
        wp_r   <= wr_addr;
        left_r <= in_left_census;
        sky_r  <= in_sky_pixel;
        if (in_row_start) begin
          col_r <= '0;
        end else if (col_r != COL_MAX) begin
          col_r <= col_r + 1'b1;
        end
      end else if (issue) begin
        grp_r <= grp_r + 1'b1;
        if (grp_is_last) begin
          busy_r <= 1'b0;
        end
      end

      if (issue) begin
        pend_r      <= 1'b1;
        pend_grp_r  <= grp_r;
        pend_last_r <= grp_is_last;
        for (int k = 0; k < COSTS_PER_RESULT; k++) begin
          pend_sel_r[k] <= lane_addr[k][LANE_W-1:0];
        end
      end else if (load) begin
        pend_r <= 1'b0;
      end

      if (load) begin
        out_valid_r      <= 1'b1;
        out_cost_r       <= lane_cost;
        out_first_disp_r <= {pend_grp_r, LANE_W'(0)};
        out_last_r       <= pend_last_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cost_a     = out_cost_r[0];
  assign out_cost_b     = out_cost_r[1];
  assign out_cost_c     = out_cost_r[2];
  assign out_cost_d     = out_cost_r[3];
  assign out_first_disp = out_first_disp_r;
  assign out_last_group = out_last_r;

`ifndef ASSERT_OFF
  // A group that is not the last one leaves more work behind it.
  a_more_groups: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (busy_r || pend_r))
    else $error("non-final cost group delivered with no group left to compute");

  // Reading the last group ends the sequencing of the pixel.
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && pend_last_r) |-> !busy_r)
    else $error("sequencer still running after the last group was read");

  // The sequencer starts only on an input transaction.
  a_start_on_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(in_valid && !in_stall))
    else $error("sequencer started without an input transaction");
`endif

endmodule
